// ----- rtl/quintic_trajectory_evaluator_defines.svh -----
// Assertion macros shared by the quintic trajectory evaluator RTL.
`ifndef QUINTIC_TRAJECTORY_EVALUATOR_DEFINES_SVH
`define QUINTIC_TRAJECTORY_EVALUATOR_DEFINES_SVH

// Check cons in the same cycle as ante.
`define QTE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons after ante, delayed by n.
`define QTE_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ----- rtl/qte_pkg.sv -----
// Shared constants and types of the quintic trajectory evaluator.
package qte_pkg;

  localparam int unsigned TIME_W             = 32;
  localparam int unsigned COEF_W             = 64;
  localparam int unsigned RES_W              = 64;
  localparam int unsigned LIMB_W             = 32;
  localparam int unsigned VEL_D_W            = 67;  // up to 5 x coefficient
  localparam int unsigned ACC_D_W            = 69;  // up to 20 x coefficient
  localparam int unsigned NUM_COEF           = 6;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = 64;
  localparam int unsigned DEF_TIME_FRAC_BITS = 16;
  localparam int unsigned POS_DEG            = 5;
  localparam int unsigned VEL_DEG            = 4;
  localparam int unsigned ACC_DEG            = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COEF0   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_T_START = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_T_END   = CFG_IDX_W'(7);

  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] t;
  } tctl_t;

  typedef struct packed {
    logic             valid;
    logic             sat;
    logic [RES_W-1:0] value;
  } res_t;

endpackage

// ----- rtl/qte_horner_step.sv -----
// One exact Horner step h*t + (d << SHIFT): limb multiply stage, then sum stage.
module qte_horner_step #(
  parameter int unsigned IN_W  = 64,
  parameter int unsigned D_W   = 64,
  parameter int unsigned SHIFT = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qte_pkg::tctl_t                       ctl_i,
  input  logic [IN_W-1:0]                      h_i,
  input  logic signed [D_W-1:0]                d_i,
  output qte_pkg::tctl_t                       ctl_o,
  output logic [IN_W+qte_pkg::LIMB_W-1:0]      h_o
);

  localparam int unsigned LW    = qte_pkg::LIMB_W;
  localparam int unsigned PW    = 2 * LW;
  localparam int unsigned NL    = IN_W / LW;
  localparam int unsigned OUT_W = IN_W + LW;

  // Partial products carry their sign bit inverted; this constant removes the bias.
  function automatic logic [OUT_W-1:0] bias_f();
    logic [OUT_W-1:0] b;
    b = '0;
    for (int i = 0; i < NL; i++) begin
      b[LW*i+PW-1] = 1'b1;
    end
    return ~b + OUT_W'(1);
  endfunction

  localparam logic [OUT_W-1:0] KBIAS = bias_f();

  logic [PW-1:0]    pp [NL];
  logic [OUT_W-1:0] e_d, o_d, f_d, dext;
  logic [OUT_W-1:0] e_q, o_q, f_q, h_q;
  qte_pkg::tctl_t   ctl_a_q, ctl_b_q;

  for (genvar i = 0; i < NL; i++) begin : g_limb
    logic signed [LW:0] limb_s;
    logic signed [PW:0] prod;
    // lower limbs unsigned, top limb carries the sign
    assign limb_s = (i == NL - 1) ? $signed({h_i[LW*i+LW-1], h_i[LW*i +: LW]})
                                  : $signed({1'b0, h_i[LW*i +: LW]});
    assign prod   = limb_s * $signed(ctl_i.t);
    assign pp[i]  = {~prod[PW-1], prod[PW-2:0]};
  end

  // even and odd products do not overlap, so each set packs into one word
  always_comb begin
    e_d = '0;
    o_d = '0;
    for (int i = 0; i < NL; i++) begin
      if ((i % 2) == 0) begin
        e_d[LW*i +: PW] = pp[i];
      end else begin
        o_d[LW*i +: PW] = pp[i];
      end
    end
  end

  assign dext = OUT_W'(d_i);
  assign f_d  = (dext << SHIFT) + KBIAS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
    o_q <= o_d;
    f_q <= f_d;
    h_q <= e_q + o_q + f_q;
  end

  assign ctl_o = ctl_b_q;
  assign h_o   = h_q;

endmodule

// ----- rtl/qte_round_sat.sv -----
// Round to nearest (ties up), scale back to Q32.32 and saturate.
module qte_round_sat #(
  parameter int unsigned IN_W  = 224,
  parameter int unsigned TOTAL = 80
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     h_i,
  output qte_pkg::res_t       res_o
);

  localparam int unsigned RW = qte_pkg::RES_W;
  localparam logic [IN_W-1:0] HALF = IN_W'(1) << (TOTAL - 1);

  logic signed [IN_W-1:0] sum_s, sh;
  logic [IN_W-RW:0]       upper;
  logic                   fits;
  logic [RW-1:0]          value_d;
  logic                   valid_q, sat_q;
  logic [RW-1:0]          value_q;

  assign sum_s = $signed(h_i + HALF);
  assign sh    = sum_s >>> TOTAL;
  assign upper = sh[IN_W-1:RW-1];
  assign fits  = (&upper) | ~(|upper);

  always_comb begin
    if (fits) begin
      value_d = sh[RW-1:0];
    end else if (sh[IN_W-1]) begin
      value_d = qte_pkg::RES_MIN;
    end else begin
      value_d = qte_pkg::RES_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q   <= ~fits;
    value_q <= value_d;
  end

  assign res_o.valid = valid_q;
  assign res_o.sat   = sat_q;
  assign res_o.value = value_q;

endmodule

// ----- rtl/qte_lane.sv -----
// One polynomial lane: chain of Horner steps followed by rounding.
module qte_lane #(
  parameter int unsigned DEG       = 5,
  parameter int unsigned D_W       = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qte_pkg::tctl_t         ctl_i,
  input  logic signed [D_W-1:0]  d_i [DEG+1],
  output qte_pkg::res_t          res_o
);

  localparam int unsigned LW   = qte_pkg::LIMB_W;
  localparam int unsigned W0   = ((D_W + LW - 1) / LW) * LW;
  localparam int unsigned WMAX = W0 + LW * DEG;

  logic [WMAX-1:0] h_chain   [DEG+1];
  qte_pkg::tctl_t  ctl_chain [DEG+1];

  // seed with the leading coefficient
  assign h_chain[0]   = WMAX'(d_i[DEG]);
  assign ctl_chain[0] = ctl_i;

  for (genvar s = 1; s <= DEG; s++) begin : g_step
    localparam int unsigned IN_W = W0 + LW * (s - 1);
    logic [IN_W+LW-1:0] h_step;

    qte_horner_step #(
      .IN_W  (IN_W),
      .D_W   (D_W),
      .SHIFT (FRAC_BITS * s)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_chain[s-1]),
      .h_i    (h_chain[s-1][IN_W-1:0]),
      .d_i    (d_i[DEG-s]),
      .ctl_o  (ctl_chain[s]),
      .h_o    (h_step)
    );

    assign h_chain[s] = WMAX'($signed(h_step));
  end

  qte_round_sat #(
    .IN_W  (WMAX),
    .TOTAL (DEG * FRAC_BITS)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ctl_chain[DEG].valid),
    .h_i     (h_chain[DEG]),
    .res_o   (res_o)
  );

endmodule

// ----- rtl/quintic_trajectory_evaluator.sv -----
// Top level of the quintic trajectory evaluator: configuration, clamp, lanes, alignment.
//
// Usage
//   Input channel: drive sample_time_i (signed, TIME_FRAC_BITS fraction bits) and
//   raise start_i; the word is taken at a rising edge where start_i is high and
//   busy_o is low. busy_o is high in reset and the first cycle after its release.
//   Output channel: done_o is high for exactly one cycle with position_o,
//   velocity_o, acceleration_o (signed Q32.32) and saturated_o; the receiver
//   takes the word at the edge that ends that cycle and cannot hold it off.
//   Configuration: cfg_we_i with cfg_idx_i and cfg_data_i writes one register per
//   edge (coef0..coef5, t_start, t_end); write only while no word is in flight.
// Timing
//   One word per cycle, back to back, whenever busy_o is low. A word passes the
//   clamp register and then the lanes; the position lane is the longest: five
//   Horner steps of two stages each (limb multiply, then a three-input sum) plus
//   one rounding stage; the shorter velocity and acceleration lanes are delayed
//   to line up with it.
// Reset
//   Reset clears every valid bit, returns the coefficients and t_start to zero
//   and t_end to 1.0. There is no back-pressure, so the pipeline never stalls.
`include "quintic_trajectory_evaluator_defines.svh"

module quintic_trajectory_evaluator #(
  parameter int unsigned TIME_FRAC_BITS = qte_pkg::DEF_TIME_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [qte_pkg::TIME_W-1:0]  sample_time_i,
  input  logic                               cfg_we_i,
  input  logic [qte_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qte_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                               done_o,
  output logic signed [qte_pkg::RES_W-1:0]   position_o,
  output logic signed [qte_pkg::RES_W-1:0]   velocity_o,
  output logic signed [qte_pkg::RES_W-1:0]   acceleration_o,
  output logic                               saturated_o
);

  localparam int unsigned IW      = qte_pkg::CFG_IDX_W;
  localparam int unsigned TW      = qte_pkg::TIME_W;
  localparam int unsigned CW      = qte_pkg::COEF_W;
  localparam int unsigned VW      = qte_pkg::VEL_D_W;
  localparam int unsigned AW      = qte_pkg::ACC_D_W;
  localparam int unsigned VEL_DLY = 2 * (qte_pkg::POS_DEG - qte_pkg::VEL_DEG);
  localparam int unsigned ACC_DLY = 2 * (qte_pkg::POS_DEG - qte_pkg::ACC_DEG);
  // accept edge to result edge: clamp register, two stages per step, rounding
  localparam int unsigned LATENCY = 2 * qte_pkg::POS_DEG + 2;
  localparam logic [TW-1:0] T_END_RESET = TW'(1) << TIME_FRAC_BITS;

  // configuration; derivative coefficients are scaled as they are written
  logic signed [CW-1:0] coef_q [qte_pkg::NUM_COEF];
  logic signed [VW-1:0] dv_q   [qte_pkg::VEL_DEG+1];
  logic signed [AW-1:0] da_q   [qte_pkg::ACC_DEG+1];
  logic signed [TW-1:0] t_start_q, t_end_q;

  logic                 init_q;
  logic                 accept;
  logic signed [TW-1:0] t_clamp;
  qte_pkg::tctl_t       ctl0_q;

  qte_pkg::res_t pos_res, vel_res, acc_res;
  qte_pkg::res_t vel_dly_q [VEL_DLY];
  qte_pkg::res_t acc_dly_q [ACC_DLY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < qte_pkg::NUM_COEF; k++) begin
        coef_q[k] <= '0;
      end
      for (int k = 0; k <= qte_pkg::VEL_DEG; k++) begin
        dv_q[k] <= '0;
      end
      for (int k = 0; k <= qte_pkg::ACC_DEG; k++) begin
        da_q[k] <= '0;
      end
      t_start_q <= '0;
      t_end_q   <= T_END_RESET;
    end else if (cfg_we_i) begin
      for (int k = 0; k < qte_pkg::NUM_COEF; k++) begin
        if (cfg_idx_i == qte_pkg::REG_COEF0 + IW'(k)) begin
          coef_q[k] <= $signed(cfg_data_i[CW-1:0]);
        end
      end
      // first derivative: (k+1) * coef(k+1)
      for (int k = 0; k <= qte_pkg::VEL_DEG; k++) begin
        if (cfg_idx_i == qte_pkg::REG_COEF0 + IW'(k + 1)) begin
          dv_q[k] <= VW'($signed(cfg_data_i[CW-1:0])) * $signed(VW'(k + 1));
        end
      end
      // second derivative: (k+1)(k+2) * coef(k+2)
      for (int k = 0; k <= qte_pkg::ACC_DEG; k++) begin
        if (cfg_idx_i == qte_pkg::REG_COEF0 + IW'(k + 2)) begin
          da_q[k] <= AW'($signed(cfg_data_i[CW-1:0])) * $signed(AW'((k + 1) * (k + 2)));
        end
      end
      if (cfg_idx_i == qte_pkg::REG_T_START) begin
        t_start_q <= $signed(cfg_data_i[TW-1:0]);
      end
      if (cfg_idx_i == qte_pkg::REG_T_END) begin
        t_end_q <= $signed(cfg_data_i[TW-1:0]);
      end
    end
  end

  // hold off the first cycle after reset release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
    end else begin
      init_q <= 1'b1;
    end
  end

  assign busy_o = ~init_q;
  assign accept = start_i & ~busy_o;

  // clamp: the lower bound wins, so an inverted window still gives one answer
  always_comb begin
    if (sample_time_i <= t_start_q) begin
      t_clamp = t_start_q;
    end else if (sample_time_i >= t_end_q) begin
      t_clamp = t_end_q;
    end else begin
      t_clamp = sample_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q.valid <= accept;
      ctl0_q.t     <= t_clamp;
    end
  end

  qte_lane #(
    .DEG       (qte_pkg::POS_DEG),
    .D_W       (CW),
    .FRAC_BITS (TIME_FRAC_BITS)
  ) u_pos_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl0_q),
    .d_i    (coef_q),
    .res_o  (pos_res)
  );

  qte_lane #(
    .DEG       (qte_pkg::VEL_DEG),
    .D_W       (VW),
    .FRAC_BITS (TIME_FRAC_BITS)
  ) u_vel_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl0_q),
    .d_i    (dv_q),
    .res_o  (vel_res)
  );

  qte_lane #(
    .DEG       (qte_pkg::ACC_DEG),
    .D_W       (AW),
    .FRAC_BITS (TIME_FRAC_BITS)
  ) u_acc_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl0_q),
    .d_i    (da_q),
    .res_o  (acc_res)
  );

  // delay the shorter lanes so all three results leave together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VEL_DLY; i++) begin
        vel_dly_q[i] <= '0;
      end
      for (int i = 0; i < ACC_DLY; i++) begin
        acc_dly_q[i] <= '0;
      end
    end else begin
      vel_dly_q[0] <= vel_res;
      for (int i = 1; i < VEL_DLY; i++) begin
        vel_dly_q[i] <= vel_dly_q[i-1];
      end
      acc_dly_q[0] <= acc_res;
      for (int i = 1; i < ACC_DLY; i++) begin
        acc_dly_q[i] <= acc_dly_q[i-1];
      end
    end
  end

  assign done_o         = pos_res.valid;
  assign position_o     = $signed(pos_res.value);
  assign velocity_o     = $signed(vel_dly_q[VEL_DLY-1].value);
  assign acceleration_o = $signed(acc_dly_q[ACC_DLY-1].value);
  assign saturated_o    = pos_res.sat | vel_dly_q[VEL_DLY-1].sat | acc_dly_q[ACC_DLY-1].sat;

  `QTE_ASSERT(a_lanes_aligned, 1'b1,
    (pos_res.valid == vel_dly_q[VEL_DLY-1].valid) &&
    (pos_res.valid == acc_dly_q[ACC_DLY-1].valid), "lane results out of step")

  `QTE_ASSERT_DLY(a_result_follows, accept, LATENCY, done_o, "accepted word produced no result")

  `QTE_ASSERT(a_no_spurious, done_o, $past(accept, LATENCY), "result without an accepted word")

  `QTE_ASSERT(a_sat_at_limit, done_o && saturated_o,
    (position_o == qte_pkg::RES_MAX) || (position_o == qte_pkg::RES_MIN) ||
    (velocity_o == qte_pkg::RES_MAX) || (velocity_o == qte_pkg::RES_MIN) ||
    (acceleration_o == qte_pkg::RES_MAX) || (acceleration_o == qte_pkg::RES_MIN),
    "saturation flag without a limit value")

endmodule

// ----- tb/qte_motion_checker.sv -----
// Checker for the quintic trajectory evaluator: predicts every result word and compares it.
`timescale 1ns / 100ps

module qte_motion_checker #(
  parameter int unsigned TIME_FRAC_BITS = qte_pkg::DEF_TIME_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [qte_pkg::TIME_W-1:0]     sample_time_i,
  input  logic                           cfg_we_i,
  input  logic [qte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [qte_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           done_i,
  input  logic [qte_pkg::RES_W-1:0]      position_i,
  input  logic [qte_pkg::RES_W-1:0]      velocity_i,
  input  logic [qte_pkg::RES_W-1:0]      acceleration_i,
  input  logic                           saturated_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import qte_pkg::*;

  localparam int FB          = TIME_FRAC_BITS;
  localparam int ACC_BITS    = 256;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [ACC_BITS-1:0] wide_t;

  typedef struct packed {
    logic [RES_W-1:0] position;
    logic [RES_W-1:0] velocity;
    logic [RES_W-1:0] acceleration;
    logic             saturated;
  } motion_t;

  logic [COEF_W-1:0] coef_r [NUM_COEF];
  logic [TIME_W-1:0] t_start_r;
  logic [TIME_W-1:0] t_end_r;
  motion_t           motion_q [$];
  int                fail_cnt    = 0;
  int                pending_cnt = 0;
  int                words_seen  = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  function automatic wide_t widen(input logic [COEF_W-1:0] v);
    return $signed({{(ACC_BITS-COEF_W){v[COEF_W-1]}}, v});
  endfunction

  // Clamp the time, then run Horner exactly on each lane; round to Q32.32 with ties
  // toward plus infinity and saturate to 64 bits.
  function automatic motion_t predict_motion(input logic [TIME_W-1:0] t_raw);
    logic [TIME_W-1:0] t_eff;
    wide_t             t_w;
    wide_t             acc;
    wide_t             half;
    wide_t             factor;
    wide_t             term [NUM_COEF];
    logic [RES_W-1:0]  lane_res [3];
    logic              sat;
    int                deg;
    int                shift;
    int                j;
    int                k;
    int                lane;
    motion_t           m;
    if ($signed(t_raw) <= $signed(t_start_r)) t_eff = t_start_r;
    else if ($signed(t_raw) >= $signed(t_end_r)) t_eff = t_end_r;
    else t_eff = t_raw;
    t_w = $signed({{(ACC_BITS-TIME_W){t_eff[TIME_W-1]}}, t_eff});
    sat = 1'b0;
    for (lane = 0; lane < 3; lane++) begin
      deg = POS_DEG - lane;
      for (k = 0; k <= deg; k++) begin
        // derivative weight: 1, (k+1) or (k+1)(k+2)
        factor  = (lane == 0) ? 1 : (lane == 1) ? k + 1 : (k + 1) * (k + 2);
        term[k] = widen(coef_r[k + lane]) * factor;
      end
      acc = term[deg];
      for (j = deg - 1; j >= 0; j--) acc = acc * t_w + (term[j] <<< (FB * (deg - j)));
      shift = deg * FB;
      half  = wide_t'(1) <<< (shift - 1);
      acc   = (acc + half) >>> shift;
      if (acc[ACC_BITS-1:RES_W-1] !== {(ACC_BITS-RES_W+1){acc[RES_W-1]}}) begin
        sat            = 1'b1;
        lane_res[lane] = acc[ACC_BITS-1] ? RES_MIN : RES_MAX;
      end else begin
        lane_res[lane] = acc[RES_W-1:0];
      end
    end
    m.position     = lane_res[0];
    m.velocity     = lane_res[1];
    m.acceleration = lane_res[2];
    m.saturated    = sat;
    return m;
  endfunction

  task automatic note_failure(input string what, input motion_t want, input motion_t got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      $display("%0t: word %0d: %s", $time, words_seen, what);
      $display("  expected pos %h vel %h acc %h sat %b",
               want.position, want.velocity, want.acceleration, want.saturated);
      $display("  actual   pos %h vel %h acc %h sat %b",
               got.position, got.velocity, got.acceleration, got.saturated);
    end
  endtask

  // Retire, predict, then apply writes: the block never sees a write and a sample together.
  always @(posedge clk_i) begin : watch
    motion_t got;
    motion_t want;
    int      k;
    if (!rst_ni) begin
      for (k = 0; k < NUM_COEF; k++) coef_r[k] = '0;
      t_start_r = '0;
      t_end_r   = TIME_W'(1) << FB;
      motion_q.delete();
    end else begin
      if (done_i) begin
        got.position     = position_i;
        got.velocity     = velocity_i;
        got.acceleration = acceleration_i;
        got.saturated    = saturated_i;
        if (motion_q.size() == 0) begin
          note_failure("result word with none expected", got, got);
        end else begin
          want = motion_q.pop_front();
          if (got.position !== want.position || got.velocity !== want.velocity ||
              got.acceleration !== want.acceleration || got.saturated !== want.saturated)
            note_failure("result word differs", want, got);
        end
        words_seen++;
      end
      if (start_i && !busy_i) motion_q.insert(motion_q.size(), predict_motion(sample_time_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_T_START) t_start_r = cfg_data_i[TIME_W-1:0];
        else if (cfg_idx_i == REG_T_END) t_end_r = cfg_data_i[TIME_W-1:0];
        else coef_r[cfg_idx_i - REG_COEF0] = cfg_data_i;
      end
    end
    pending_cnt = motion_q.size();
  end

endmodule

// ----- tb/quintic_trajectory_evaluator_tb.sv -----
// Testbench top for the quintic trajectory evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module quintic_trajectory_evaluator_tb;
  import qte_pkg::*;

  localparam int unsigned FRAC_BITS      = DEF_TIME_FRAC_BITS;
  // Generous: about 1700 words with idle gaps and many drains.
  localparam int          CYCLE_LIMIT    = 200000;
  // Long enough after the final drain for any stray word to come out.
  localparam int          SETTLE_CYCLES  = 24;
  localparam int          WORDS_PER_SET  = 110;
  localparam int          SETS_PER_PHASE = 5;

  // Q16.16 and Q32.32 values used by the directed part (16 fraction bits assumed).
  localparam logic [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] Q_ONE = 64'h0000_0001_0000_0000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [TIME_W-1:0]     sample_time_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  logic [RES_W-1:0]      position_o;
  logic [RES_W-1:0]      velocity_o;
  logic [RES_W-1:0]      acceleration_o;
  logic                  saturated_o;

  int fail_count;
  int pending;
  int cycle_cnt;
  int idle_pct;

  // Configuration that the next load_config writes.
  logic [COEF_W-1:0] coef_set [NUM_COEF];
  logic [TIME_W-1:0] t_lo;
  logic [TIME_W-1:0] t_hi;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  quintic_trajectory_evaluator #(
    .TIME_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_time_i  (sample_time_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .saturated_o    (saturated_o)
  );

  qte_motion_checker #(
    .TIME_FRAC_BITS(FRAC_BITS)
  ) motion_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .sample_time_i  (sample_time_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_i         (done_o),
    .position_i     (position_o),
    .velocity_i     (velocity_o),
    .acceleration_i (acceleration_o),
    .saturated_i    (saturated_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Present one sample time and hold it until the word is taken. busy_o is registered,
  // so its value at the falling edge is the one the next rising edge sees. Return on
  // the accept edge with start_i still high, so a following word goes back to back.
  task automatic send_word(input logic [TIME_W-1:0] t);
    logic taken;
    start_i       <= 1'b1;
    sample_time_i <= t;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
  endtask

  // Drop start and hold off until every expected word has come back. Sample the count
  // at the falling edge only, clear of the checker's update at the rising one.
  task automatic drain();
    start_i       <= 1'b0;
    sample_time_i <= $urandom;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Write all eight registers, one per edge. The upper half of the time registers'
  // data carries noise, which the block must drop.
  task automatic load_config();
    int k;
    for (k = 0; k < NUM_COEF; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_COEF0 + CFG_IDX_W'(k);
      cfg_data_i <= coef_set[k];
      @(posedge clk_i);
    end
    cfg_idx_i  <= REG_T_START;
    cfg_data_i <= {$urandom, t_lo};
    @(posedge clk_i);
    cfg_idx_i  <= REG_T_END;
    cfg_data_i <= {$urandom, t_hi};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Coefficients of every size and sign, with the extremes now and then.
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return {$urandom, $urandom};
      1:       return RES_MAX;
      2:       return RES_MIN;
      3:       return '0;
      default: return $signed({$urandom, $urandom}) >>> $urandom_range(16, 62);
    endcase
  endfunction

  // Times mostly within a few tens of seconds, sometimes anywhere in the range.
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return T_MIN;
      2:       return T_MAX;
      default: return $signed($urandom) >>> $urandom_range(10, 30);
    endcase
  endfunction

  // Aim at the window: its bounds, one step past them, inside it, and stray values.
  function automatic logic [TIME_W-1:0] pick_sample();
    longint lo;
    longint hi;
    lo = $signed(t_lo);
    hi = $signed(t_hi);
    case ($urandom_range(0, 11))
      0: return t_lo;
      1: return t_hi;
      2: return t_lo - 1'b1;
      3: return t_hi + 1'b1;
      4: return $urandom;
      5: return pick_time();
      default: begin
        if (hi > lo) return TIME_W'(lo + (longint'($urandom) % (hi - lo + 1)));
        else return pick_time();
      end
    endcase
  endfunction

  // Mostly an ordered window; now and then an empty or an inverted one.
  task automatic random_setup();
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    int                k;
    for (k = 0; k < NUM_COEF; k++) coef_set[k] = pick_coef();
    a = pick_time();
    b = pick_time();
    case ($urandom_range(0, 9))
      0: begin
        t_lo = a;
        t_hi = a;
      end
      1: begin
        t_lo = ($signed(a) > $signed(b)) ? a : b;
        t_hi = ($signed(a) > $signed(b)) ? b : a;
      end
      default: begin
        t_lo = ($signed(a) > $signed(b)) ? b : a;
        t_hi = ($signed(a) > $signed(b)) ? a : b;
      end
    endcase
  endtask

  initial begin : stimulus
    int phase;
    int set_idx;
    int n;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    sample_time_i = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    idle_pct      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: zero coefficients, window [0, 1.0]; the first word meets busy.
    send_word('0);
    send_word(T_MAX);
    send_word(T_MIN);

    // Mixed coefficients over [-2.0, 3.0]: both bounds, clamping on either side,
    // rounding ties at +/-0.5 on the one-ulp linear term, and the range ends.
    drain();
    coef_set = '{Q_ONE, 64'd1, -64'sd3, 64'd5, 64'h0000_0002_8000_0000,
                 64'hFFFF_FFFF_C000_0000};
    t_lo = 32'hFFFE_0000;
    t_hi = 32'h0003_0000;
    load_config();
    send_word(32'hFFFE_0000);
    send_word(32'h0003_0000);
    send_word(32'hFFF9_0000);
    send_word(32'h0009_0000);
    send_word(32'h0000_8000);
    send_word(32'hFFFF_8000);
    send_word(32'h0000_0001);
    send_word('0);
    send_word(T_MIN);
    send_word(T_MAX);

    // Largest coefficients over the whole time range: saturation of both signs.
    drain();
    coef_set = '{RES_MAX, RES_MAX, RES_MAX, RES_MAX, RES_MAX, RES_MAX};
    t_lo = T_MIN;
    t_hi = T_MAX;
    load_config();
    send_word(T_MAX);
    send_word(T_MIN);
    send_word('0);
    drain();
    coef_set = '{RES_MIN, RES_MIN, RES_MIN, RES_MIN, RES_MIN, RES_MIN};
    load_config();
    send_word(T_MAX);
    send_word(T_MIN);

    // Inverted window, start 2.0 and end -1.0: up to the start gives the start,
    // anything later gives the end.
    drain();
    coef_set = '{Q_ONE, 64'd1, -64'sd3, 64'd5, 64'h0000_0002_8000_0000,
                 64'hFFFF_FFFF_C000_0000};
    t_lo = 32'h0002_0000;
    t_hi = 32'hFFFF_0000;
    load_config();
    send_word(32'h0003_0000);
    send_word(32'h0001_0000);
    send_word(32'h0002_0000);
    send_word(32'hFFFC_0000);

    // Empty window at 0.75: every time collapses onto it.
    drain();
    t_lo = 32'h0000_C000;
    t_hi = 32'h0000_C000;
    load_config();
    send_word(32'hFFFF_0000);
    send_word(32'h0005_0000);

    // Random part: the sender idles with a chance of 23 and then 78 percent, then never.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 78 : 0;
      for (set_idx = 0; set_idx < SETS_PER_PHASE; set_idx++) begin
        drain();
        random_setup();
        load_config();
        for (n = 0; n < WORDS_PER_SET; n++) begin
          send_word(pick_sample());
          if ($urandom_range(0, 299) == 0) begin
            drain();
          end else begin
            // idle each cycle with the phase's chance
            while ($urandom_range(0, 99) < idle_pct) begin
              start_i       <= 1'b0;
              sample_time_i <= $urandom;
              @(posedge clk_i);
            end
          end
        end
      end
    end

    // Wait out the pipeline, then allow for any stray word.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** quintic_trajectory_evaluator: PASSED **");
    end else begin
      $display("** quintic_trajectory_evaluator: FAILED **");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** quintic_trajectory_evaluator: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qte_pkg.sv
rtl/qte_horner_step.sv
rtl/qte_round_sat.sv
rtl/qte_lane.sv
rtl/quintic_trajectory_evaluator.sv
tb/qte_motion_checker.sv
tb/quintic_trajectory_evaluator_tb.sv
